[rtl/lmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants of the lcd mode timing block
// Request and result layouts, operation and mode codes, timing constants.
// ----------------------------------------------------------------------------
package lmt_pkg;

   // timing of one line and its phases
   localparam logic [9:0] LINE_DOTS      = 10'd456;
   localparam logic [9:0] OAM_DOTS       = 10'd80;
   localparam logic [9:0] DOT_MAX        = 10'd1023;
   localparam logic [9:0] EARLY_ZERO_DOT = 10'd4;
   localparam logic [9:0] LCD_ON_DOT     = 10'd4;
   localparam logic [8:0] XFER_BASE      = 9'd252;
   localparam logic [8:0] WIN_EXTRA      = 9'd16;
   localparam logic [7:0] WX_LIMIT       = 8'd166;
   localparam logic [7:0] VBLANK_LINE    = 8'd144;
   localparam logic [7:0] LAST_LINE      = 8'd153;

   // stat and lcdc bit positions
   localparam int STAT_LYC_FLAG = 2;
   localparam int STAT_HBL_EN   = 3;
   localparam int STAT_VBL_EN   = 4;
   localparam int STAT_OAM_EN   = 5;
   localparam int STAT_LYC_EN   = 6;
   localparam int STAT_ONE      = 7;
   localparam int LCDC_WIN_EN   = 5;
   localparam int LCDC_ENABLE   = 7;

   localparam logic [7:0] STAT_WR_MASK   = 8'h78;
   localparam logic [7:0] STAT_KEEP_MASK = 8'h07;
   localparam logic [7:0] STAT_ALL_ONES  = 8'hFF;

   typedef enum logic [1:0] {
      PPU_HBLANK = 2'd0,
      PPU_VBLANK = 2'd1,
      PPU_OAM    = 2'd2,
      PPU_XFER   = 2'd3
   } ppu_state_type;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_WR_STAT = 3'd1,
      OP_WR_LYC  = 3'd2,
      OP_WR_WY   = 3'd3,
      OP_WR_WX   = 3'd4,
      OP_WR_SCX  = 3'd5,
      OP_WR_LCDC = 3'd6,
      OP_RD_STAT = 3'd7
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [8:0] dots;
      logic [7:0] value;
   } item_type;

   typedef struct packed {
      logic [7:0] line_number;
      logic [1:0] shown_mode;
      logic [7:0] status_read;
      logic       vblank_irq;
      logic       stat_irq;
      logic       vram_locked;
      logic       scan_sprites;
      logic       render_line;
      logic       frame_done;
   } result_type;

   typedef struct packed {
      logic       signal;
      logic       rise;
      logic [7:0] bits;
   } stat_out_type;

endpackage

[rtl/lmt_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_req_if: request channel
// Valid/ready channel carrying one tick or register access.
// ----------------------------------------------------------------------------
interface lmt_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [8:0] dots;
   logic [7:0] value;

   modport source (output valid, output mode, output dots, output value, input ready);
   modport sink (input valid, input mode, input dots, input value, output ready);
endinterface

[rtl/lmt_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_rsp_if: result channel
// Valid/ready channel carrying the status view after one request.
// ----------------------------------------------------------------------------
interface lmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_number;
   logic [1:0] shown_mode;
   logic [7:0] status_read;
   logic       vblank_irq;
   logic       stat_irq;
   logic       vram_locked;
   logic       scan_sprites;
   logic       render_line;
   logic       frame_done;

   modport source (output valid, output line_number, output shown_mode,
                   output status_read, output vblank_irq, output stat_irq,
                   output vram_locked, output scan_sprites, output render_line,
                   output frame_done, input ready);
   modport sink (input valid, input line_number, input shown_mode,
                 input status_read, input vblank_irq, input stat_irq,
                 input vram_locked, input scan_sprites, input render_line,
                 input frame_done, output ready);
endinterface

[rtl/lcd_mode_timing_stat_irq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_stat_irq: lcd mode timing and stat interrupt core
// Top level joining the request decode queue and the execution side.
// ----------------------------------------------------------------------------
// Every request (dot tick, register write or stat read) gives exactly one
// response, in order. A new request can be accepted every cycle while the
// queue has room: the execution side applies one request per cycle while
// the output register is free or being taken, so the sustained rate is one
// request per clock unless responses stall. An accepted request enters a
// two-entry queue, is executed from its head and its response is held in an
// output register. The queue and the output register let the request side
// keep going while a response waits to be taken. After reset the lcd is off;
// csr_wr_data selects color-model behavior when written.
// ----------------------------------------------------------------------------
module lcd_mode_timing_stat_irq (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   lmt_req_if.sink   req_bus,
   lmt_rsp_if.source rsp_bus
);

   logic              q_valid;
   logic              q_pop;
   lmt_pkg::item_type q_item;

   lmt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   lmt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

[rtl/lmt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_front: request decode and queue
// Classifies each request into an operation and holds it in a two-entry
// queue until the execution side takes it.
// ----------------------------------------------------------------------------
module lmt_front (
   input  logic                clock,
   input  logic                reset,
   lmt_req_if.sink             req_bus,
   output logic                q_valid,
   output lmt_pkg::item_type   q_item,
   input  logic                q_pop
);

   lmt_pkg::item_type q_ff [2];
   lmt_pkg::item_type dec_item;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   always_comb begin
      dec_item.dots  = '0;
      dec_item.value = '0;
      case (req_bus.mode)
         lmt_pkg::OP_TICK: begin
            dec_item.op   = lmt_pkg::OP_TICK;
            dec_item.dots = req_bus.dots;
         end
         lmt_pkg::OP_WR_STAT: dec_item.op = lmt_pkg::OP_WR_STAT;
         lmt_pkg::OP_WR_LYC:  dec_item.op = lmt_pkg::OP_WR_LYC;
         lmt_pkg::OP_WR_WY:   dec_item.op = lmt_pkg::OP_WR_WY;
         lmt_pkg::OP_WR_WX:   dec_item.op = lmt_pkg::OP_WR_WX;
         lmt_pkg::OP_WR_SCX:  dec_item.op = lmt_pkg::OP_WR_SCX;
         lmt_pkg::OP_WR_LCDC: dec_item.op = lmt_pkg::OP_WR_LCDC;
         default: dec_item.op = lmt_pkg::OP_RD_STAT;
      endcase
      // only writes carry data
      if (dec_item.op != lmt_pkg::OP_TICK && dec_item.op != lmt_pkg::OP_RD_STAT) begin
         dec_item.value = req_bus.value;
      end
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign q_valid       = (count_ff != 2'd0);
   assign q_item        = q_ff[rd_ptr_ff];
   assign pop           = q_valid && q_pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count missed a push");
`endif

endmodule

[rtl/lmt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_back: mode timing execution
// Applies one queued request per cycle, unless a result waits untaken, to the
// mode, line and dot state, evaluates the stat irq line, registers the result.
// ----------------------------------------------------------------------------
module lmt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                q_valid,
   input  lmt_pkg::item_type   q_item,
   output logic                q_pop,
   lmt_rsp_if.source           rsp_bus
);

   function automatic lmt_pkg::stat_out_type stat_eval(
      input logic [7:0]             status,
      input logic [7:0]             cmp,
      input logic [7:0]             shown_ln,
      input logic                   glitch,
      input lmt_pkg::ppu_state_type st,
      input logic                   old_sig
   );
      lmt_pkg::stat_out_type r;
      logic                  hit;
      logic                  lyc_sig;
      logic                  sig;
      logic [7:0]            s;
      hit = (cmp == shown_ln);
      s = status;
      s[lmt_pkg::STAT_LYC_FLAG] = hit;
      lyc_sig = s[lmt_pkg::STAT_LYC_EN] && hit;
      if (glitch) begin
         sig = lyc_sig;
      end else begin
         case (st)
            lmt_pkg::PPU_HBLANK: sig = s[lmt_pkg::STAT_HBL_EN] || lyc_sig;
            lmt_pkg::PPU_VBLANK: sig = s[lmt_pkg::STAT_VBL_EN] || lyc_sig;
            lmt_pkg::PPU_OAM:    sig = s[lmt_pkg::STAT_OAM_EN] || lyc_sig;
            default:             sig = lyc_sig;
         endcase
      end
      r.signal = sig;
      r.rise   = !old_sig && sig;
      r.bits   = s;
      r.bits[lmt_pkg::STAT_ONE] = 1'b1;
      return r;
   endfunction

   lmt_pkg::ppu_state_type state_ff, state_in;
   logic [9:0]             dot_ff, dot_in;
   logic [7:0]             line_ff, line_in;
   logic [8:0]             xfer_end_ff, xfer_end_in;
   logic                   irq_sig_ff, irq_sig_in;
   logic                   early_ff, early_in;
   logic                   glitch_ff, glitch_in;
   logic                   win_hit_ff, win_hit_in;
   logic [7:0]             stat_ff, stat_in;
   logic [7:0]             lyc_ff, lyc_in;
   logic [7:0]             wy_ff, wy_in;
   logic [7:0]             wx_ff, wx_in;
   logic [7:0]             scx_ff, scx_in;
   logic [7:0]             lcdc_ff, lcdc_in;
   logic                   color_ff;
   logic                   out_valid_ff;
   lmt_pkg::result_type    result_ff, result_in;
   logic                   take;

   assign take  = q_valid && (!out_valid_ff || rsp_bus.ready);
   assign q_pop = take;

   always_comb begin
      logic [10:0]           sum;
      logic [9:0]            dc;
      logic [7:0]            ln;
      logic [8:0]            tlen;
      logic [7:0]            upd_status;
      logic                  upd_glitch;
      logic                  do_upd;
      logic                  win;
      logic                  pulse;
      logic                  vb;
      logic                  scan;
      logic                  render;
      logic                  frame;
      lmt_pkg::stat_out_type su;
      lmt_pkg::stat_out_type su0;

      state_in    = state_ff;
      dot_in      = dot_ff;
      line_in     = line_ff;
      xfer_end_in = xfer_end_ff;
      irq_sig_in  = irq_sig_ff;
      early_in    = early_ff;
      glitch_in   = glitch_ff;
      win_hit_in  = win_hit_ff;
      stat_in     = stat_ff;
      lyc_in      = lyc_ff;
      wy_in       = wy_ff;
      wx_in       = wx_ff;
      scx_in      = scx_ff;
      lcdc_in     = lcdc_ff;
      sum         = {1'b0, dot_ff} + {2'b00, q_item.dots};
      dc          = sum[10] ? lmt_pkg::DOT_MAX : sum[9:0];
      ln          = line_ff + 8'd1;
      tlen        = lmt_pkg::XFER_BASE + {6'd0, scx_ff[2:0]};
      upd_status  = stat_ff;
      upd_glitch  = glitch_ff;
      do_upd      = 1'b0;
      win         = 1'b0;
      pulse       = 1'b0;
      vb          = 1'b0;
      scan        = 1'b0;
      render      = 1'b0;
      frame       = 1'b0;
      su          = '0;
      su0         = '0;

      case (q_item.op)
         lmt_pkg::OP_TICK: begin
            if (lcdc_ff[lmt_pkg::LCDC_ENABLE]) begin
               dot_in = dc;
               case (state_ff)
                  lmt_pkg::PPU_HBLANK: begin
                     if (dc >= lmt_pkg::LINE_DOTS) begin
                        dot_in  = dc - lmt_pkg::LINE_DOTS;
                        line_in = ln;
                        do_upd  = 1'b1;
                        if (ln == lmt_pkg::VBLANK_LINE) begin
                           state_in   = lmt_pkg::PPU_VBLANK;
                           frame      = 1'b1;
                           vb         = 1'b1;
                           win_hit_in = 1'b0;
                           // oam-enable also fires on vblank entry
                           if (stat_ff[lmt_pkg::STAT_OAM_EN] && !irq_sig_ff) begin
                              pulse      = 1'b1;
                              irq_sig_in = 1'b1;
                           end
                        end else begin
                           state_in = lmt_pkg::PPU_OAM;
                        end
                     end
                  end
                  lmt_pkg::PPU_VBLANK: begin
                     if (dc >= lmt_pkg::LINE_DOTS) begin
                        dot_in  = dc - lmt_pkg::LINE_DOTS;
                        line_in = ln;
                        do_upd  = 1'b1;
                        if (ln > lmt_pkg::LAST_LINE) begin
                           line_in  = 8'd0;
                           state_in = lmt_pkg::PPU_OAM;
                           early_in = 1'b0;
                        end
                     end else if (line_ff == lmt_pkg::LAST_LINE && !early_ff &&
                                  dc >= lmt_pkg::EARLY_ZERO_DOT) begin
                        early_in = 1'b1;
                        do_upd   = 1'b1;
                     end
                  end
                  lmt_pkg::PPU_OAM: begin
                     if (dc >= lmt_pkg::OAM_DOTS) begin
                        glitch_in  = 1'b0;
                        upd_glitch = 1'b0;
                        win_hit_in = win_hit_ff || (line_ff == wy_ff);
                        win = (wx_ff <= lmt_pkg::WX_LIMIT) && win_hit_in &&
                              lcdc_ff[lmt_pkg::LCDC_WIN_EN];
                        if (win && scx_ff != 8'd0) begin
                           tlen = tlen + lmt_pkg::WIN_EXTRA;
                        end
                        xfer_end_in = tlen;
                        state_in    = lmt_pkg::PPU_XFER;
                        scan        = 1'b1;
                        do_upd      = 1'b1;
                     end
                  end
                  default: begin
                     if (dc >= {1'b0, xfer_end_ff}) begin
                        render   = 1'b1;
                        state_in = lmt_pkg::PPU_HBLANK;
                        do_upd   = 1'b1;
                     end
                  end
               endcase
            end
         end
         lmt_pkg::OP_WR_STAT: begin
            stat_in = (q_item.value & lmt_pkg::STAT_WR_MASK) |
                      (stat_ff & lmt_pkg::STAT_KEEP_MASK);
            stat_in[lmt_pkg::STAT_ONE] = 1'b1;
            upd_status = stat_in;
            do_upd     = 1'b1;
            // write glitch: a pass with every enable set comes first
            if (!color_ff && lcdc_ff[lmt_pkg::LCDC_ENABLE]) begin
               su0 = stat_eval(lmt_pkg::STAT_ALL_ONES, lyc_ff,
                               early_ff ? 8'd0 : line_ff, glitch_ff, state_ff,
                               irq_sig_ff);
               irq_sig_in = su0.signal;
               pulse      = su0.rise;
            end
         end
         lmt_pkg::OP_WR_LYC: begin
            lyc_in = q_item.value;
            do_upd = 1'b1;
         end
         lmt_pkg::OP_WR_WY:  wy_in  = q_item.value;
         lmt_pkg::OP_WR_WX:  wx_in  = q_item.value;
         lmt_pkg::OP_WR_SCX: scx_in = q_item.value;
         lmt_pkg::OP_WR_LCDC: begin
            lcdc_in = q_item.value;
            if (lcdc_ff[lmt_pkg::LCDC_ENABLE] && !q_item.value[lmt_pkg::LCDC_ENABLE]) begin
               state_in   = lmt_pkg::PPU_HBLANK;
               early_in   = 1'b0;
               win_hit_in = 1'b0;
               dot_in     = 10'd0;
               line_in    = 8'd0;
            end else if (!lcdc_ff[lmt_pkg::LCDC_ENABLE] &&
                         q_item.value[lmt_pkg::LCDC_ENABLE]) begin
               // stat pass sees the old glitch flag
               state_in  = lmt_pkg::PPU_OAM;
               do_upd    = 1'b1;
               glitch_in = 1'b1;
               dot_in    = lmt_pkg::LCD_ON_DOT;
            end
         end
         default: begin
         end
      endcase

      if (do_upd && lcdc_in[lmt_pkg::LCDC_ENABLE]) begin
         su = stat_eval(upd_status, lyc_in, early_in ? 8'd0 : line_in, upd_glitch,
                        state_in, irq_sig_in);
         irq_sig_in = su.signal;
         pulse      = pulse || su.rise;
         stat_in    = su.bits;
      end

      result_in.line_number  = early_in ? 8'd0 : line_in;
      result_in.shown_mode   = glitch_in ? lmt_pkg::PPU_HBLANK : state_in;
      result_in.status_read  = {stat_in[7:2], result_in.shown_mode};
      result_in.vblank_irq   = vb;
      result_in.stat_irq     = pulse;
      result_in.vram_locked  = (state_in == lmt_pkg::PPU_XFER);
      result_in.scan_sprites = scan;
      result_in.render_line  = render;
      result_in.frame_done   = frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmt_pkg::PPU_OAM;
         dot_ff       <= '0;
         line_ff      <= '0;
         xfer_end_ff  <= '0;
         irq_sig_ff   <= 1'b0;
         early_ff     <= 1'b0;
         glitch_ff    <= 1'b0;
         win_hit_ff   <= 1'b0;
         stat_ff      <= '0;
         lyc_ff       <= '0;
         wy_ff        <= '0;
         wx_ff        <= '0;
         scx_ff       <= '0;
         lcdc_ff      <= '0;
         color_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
         if (take) begin
            state_ff     <= state_in;
            dot_ff       <= dot_in;
            line_ff      <= line_in;
            xfer_end_ff  <= xfer_end_in;
            irq_sig_ff   <= irq_sig_in;
            early_ff     <= early_in;
            glitch_ff    <= glitch_in;
            win_hit_ff   <= win_hit_in;
            stat_ff      <= stat_in;
            lyc_ff       <= lyc_in;
            wy_ff        <= wy_in;
            wx_ff        <= wx_in;
            scx_ff       <= scx_in;
            lcdc_ff      <= lcdc_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.line_number  = result_ff.line_number;
   assign rsp_bus.shown_mode   = result_ff.shown_mode;
   assign rsp_bus.status_read  = result_ff.status_read;
   assign rsp_bus.vblank_irq   = result_ff.vblank_irq;
   assign rsp_bus.stat_irq     = result_ff.stat_irq;
   assign rsp_bus.vram_locked  = result_ff.vram_locked;
   assign rsp_bus.scan_sprites = result_ff.scan_sprites;
   assign rsp_bus.render_line  = result_ff.render_line;
   assign rsp_bus.frame_done   = result_ff.frame_done;

`ifndef ASSERT_OFF
   a_scan_locks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.scan_sprites) |-> result_ff.vram_locked)
      else $error("sprite scan strobe outside transfer");
   a_render_unlocks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.render_line) |-> !result_ff.vram_locked)
      else $error("render strobe while still in transfer");
   a_frame_line: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.frame_done) |->
      (result_ff.vblank_irq && result_ff.line_number == lmt_pkg::VBLANK_LINE))
      else $error("frame strobe away from vblank entry");
   a_visible_lines: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lmt_pkg::PPU_VBLANK) |-> (line_ff < lmt_pkg::VBLANK_LINE))
      else $error("visible mode on a vblank line");
`endif

endmodule
